// ===== rtl/lom_pkg.sv =====
// shared types and record codes for the limit order matcher
package lom_pkg;

    // fixed field widths
    localparam int QTY_W  = 16;
    localparam int KIND_W = 2;

    // record kinds carried on the result tuser
    localparam logic [KIND_W-1:0] KIND_FILL = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REST = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DROP = 2'd3;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SCAN    = 6'b000010,
        ST_FILL    = 6'b000100,
        ST_MOVE    = 6'b001000,
        ST_MOVE_WR = 6'b010000,
        ST_STATUS  = 6'b100000
    } state_t;

endpackage

// ===== rtl/limit_order_matcher.sv =====
// limit order matcher: price-priority book with a sequenced scan and compaction
// each fill costs one scan over the entries in the book, paced by the single
//   registered read port of the book memory, plus a compaction that shifts each entry
//   behind a removed resting order down one place
// throughput: one order at a time, s_tready is high only between orders
// reset: aresetn low clears the entry count, sequencer and output valid; book
//   contents are not cleared and need no clearing pass
module limit_order_matcher
    import lom_pkg::*;
#(
    parameter int BOOK_DEPTH = 16,
    parameter int PRICE_BITS = 20,
    localparam int IN_W  = ((QTY_W + PRICE_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((PRICE_BITS + 2 * QTY_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // order_qty, limit_price
    input  logic                  s_tuser,   // is_buy
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // trade_price, trade_qty, maker_left_qty
    output logic [KIND_W-1:0]     m_tuser,   // record_kind
    output logic                  m_tlast    // last
);

    localparam int ENT_W = 1 + QTY_W + PRICE_BITS;
    localparam int IDX_W = $clog2(BOOK_DEPTH);
    localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

    // book memory: {side, qty, price} per entry
    logic [ENT_W-1:0] book_mem [BOOK_DEPTH];
    logic [ENT_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ENT_W-1:0] wr_data;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  buy_reg, buy_next;
    logic [QTY_W-1:0]      qty_reg, qty_next;
    logic [PRICE_BITS-1:0] limit_reg, limit_next;
    logic [CNT_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]      eval_idx_reg, eval_idx_next;
    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      best_idx_reg, best_idx_next;
    logic [QTY_W-1:0]      best_qty_reg, best_qty_next;
    logic [PRICE_BITS-1:0] best_price_reg, best_price_next;
    logic [CNT_W-1:0]      mv_idx_reg, mv_idx_next;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]      m_tdata_reg, m_tdata_next;
    logic [KIND_W-1:0]     m_tuser_reg, m_tuser_next;
    logic                  m_tlast_reg, m_tlast_next;

    logic                  in_accept;
    logic                  out_free;
    logic                  ent_buy;
    logic [QTY_W-1:0]      ent_qty;
    logic [PRICE_BITS-1:0] ent_price;
    logic                  limit_ok;
    logic                  better;
    logic                  hit;
    logic                  scan_more;
    logic [QTY_W-1:0]      take;
    logic [QTY_W-1:0]      left;
    logic [CNT_W-1:0]      mv_src;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // book memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            book_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= book_mem[rd_addr];
    end

    // fields of the entry read last cycle
    assign ent_buy   = rd_data_reg[ENT_W-1];
    assign ent_qty   = rd_data_reg[PRICE_BITS +: QTY_W];
    assign ent_price = rd_data_reg[PRICE_BITS-1:0];

    // crossing and priority compare, shared by all scan steps
    assign limit_ok  = buy_reg ? (ent_price <= limit_reg) : (ent_price >= limit_reg);
    assign better    = !found_reg ||
                       (buy_reg ? (ent_price < best_price_reg) : (ent_price > best_price_reg));
    assign hit       = eval_vld_reg && (ent_buy != buy_reg) && limit_ok && better;
    assign scan_more = scan_idx_reg < count_reg;

    // fill quantity against the chosen entry
    assign take   = (best_qty_reg < qty_reg) ? best_qty_reg : qty_reg;
    assign left   = best_qty_reg - take;
    assign mv_src = mv_idx_reg + CNT_W'(1);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        buy_next        = buy_reg;
        qty_next        = qty_reg;
        limit_next      = limit_reg;
        scan_idx_next   = scan_idx_reg;
        eval_vld_next   = 1'b0;
        eval_idx_next   = eval_idx_reg;
        found_next      = found_reg;
        best_idx_next   = best_idx_reg;
        best_qty_next   = best_qty_reg;
        best_price_next = best_price_reg;
        mv_idx_next     = mv_idx_reg;
        rd_addr         = scan_idx_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = best_idx_reg;
        wr_data         = {!buy_reg, left, best_price_reg};
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_tlast_next    = m_tlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    buy_next      = s_tuser;
                    qty_next      = s_tdata[QTY_W-1:0];
                    limit_next    = s_tdata[QTY_W +: PRICE_BITS];
                    scan_idx_next = '0;
                    found_next    = 1'b0;
                    if (s_tdata[QTY_W-1:0] == '0) begin
                        state_next = ST_STATUS;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            // issue one read per cycle, judge the entry read the cycle before
            ST_SCAN: begin
                eval_vld_next = scan_more;
                eval_idx_next = scan_idx_reg[IDX_W-1:0];
                if (scan_more) begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (hit) begin
                    found_next      = 1'b1;
                    best_idx_next   = eval_idx_reg;
                    best_qty_next   = ent_qty;
                    best_price_next = ent_price;
                end
                if (!scan_more && !eval_vld_reg) begin
                    state_next = found_reg ? ST_FILL : ST_STATUS;
                end
            end

            // emit the fill, then update or remove the resting entry
            ST_FILL: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({left, take, best_price_reg});
                    m_tuser_next  = KIND_FILL;
                    m_tlast_next  = 1'b0;
                    qty_next      = qty_reg - take;
                    if (left != '0) begin
                        wr_en      = 1'b1;
                        state_next = ST_STATUS;
                    end else begin
                        mv_idx_next = CNT_W'(best_idx_reg);
                        state_next  = ST_MOVE;
                    end
                end
            end

            // compaction: read entry behind the gap
            ST_MOVE: begin
                rd_addr = mv_src[IDX_W-1:0];
                if (mv_src < count_reg) begin
                    state_next = ST_MOVE_WR;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    if (qty_reg != '0) begin
                        scan_idx_next = '0;
                        found_next    = 1'b0;
                        state_next    = ST_SCAN;
                    end else begin
                        state_next = ST_STATUS;
                    end
                end
            end

            // compaction: write it one place down
            ST_MOVE_WR: begin
                wr_en       = 1'b1;
                wr_addr     = mv_idx_reg[IDX_W-1:0];
                wr_data     = rd_data_reg;
                mv_idx_next = mv_src;
                state_next  = ST_MOVE;
            end

            // closing record, rest the remainder if there is room
            ST_STATUS: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_W'({{QTY_W{1'b0}}, qty_reg, limit_reg});
                    m_tlast_next  = 1'b1;
                    if (qty_reg == '0) begin
                        m_tuser_next = KIND_DONE;
                    end else if (count_reg < CNT_W'(BOOK_DEPTH)) begin
                        m_tuser_next = KIND_REST;
                        wr_en        = 1'b1;
                        wr_addr      = count_reg[IDX_W-1:0];
                        wr_data      = {buy_reg, qty_reg, limit_reg};
                        count_next   = count_reg + CNT_W'(1);
                    end else begin
                        m_tuser_next = KIND_DROP;
                    end
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            eval_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            eval_vld_reg <= eval_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge aclk) begin
        buy_reg        <= buy_next;
        qty_reg        <= qty_next;
        limit_reg      <= limit_next;
        scan_idx_reg   <= scan_idx_next;
        eval_idx_reg   <= eval_idx_next;
        found_reg      <= found_next;
        best_idx_reg   <= best_idx_next;
        best_qty_reg   <= best_qty_next;
        best_price_reg <= best_price_next;
        mv_idx_reg     <= mv_idx_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
        m_tlast_reg    <= m_tlast_next;
    end

endmodule

// ===== rtl/lom_checker.sv =====
// port-level checks for the limit order matcher, bound to the top level
module lom_port_asserts
    import lom_pkg::*;
#(
    parameter int PRICE_BITS = 20,
    localparam int OUT_W = ((PRICE_BITS + 2 * QTY_W + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_W-1:0]     m_tdata,   // trade_price, trade_qty, maker_left_qty
    input logic [KIND_W-1:0]    m_tuser,   // record_kind
    input logic                 m_tlast    // last
);

    logic [QTY_W-1:0] rec_qty;
    logic [QTY_W-1:0] rec_left;

    assign rec_qty  = m_tdata[PRICE_BITS +: QTY_W];
    assign rec_left = m_tdata[PRICE_BITS + QTY_W +: QTY_W];

    // a stalled record holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result item changed while stalled");

    // only the closing status record carries last
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser != KIND_FILL)))
        else $error("last does not match record kind");

    // a fill always moves some quantity
    a_fill_qty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_FILL) |-> rec_qty != '0)
        else $error("fill with zero quantity");

    // status records: no maker quantity, zero remainder exactly when done
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (rec_left == '0) && ((m_tuser == KIND_DONE) == (rec_qty == '0)))
        else $error("bad status record");

    // one order in work at a time
    a_one_order: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while an order is in work");

endmodule

bind limit_order_matcher lom_port_asserts #(.PRICE_BITS(PRICE_BITS)) u_lom_port_asserts (.*);
